### hw/rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray box slab intersection
// Holds field widths, axis counts, sequencer states and the divider
// request and response structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

  // Number of axes that the test walks through and that the fields carry.
  localparam int AXIS_COUNT = 3;
  localparam int StoredAxes = 3;
  localparam int AxisLimit  = (AXIS_COUNT < StoredAxes) ? AXIS_COUNT : StoredAxes;
  localparam int AxisW      = $clog2(StoredAxes + 1);
  localparam int AxisIdxW   = $clog2(StoredAxes);

  // Field widths.
  localparam int CoordW    = 32;
  localparam int DirW      = 18;
  localparam int LimitW    = 31;
  localparam int DistW     = 31;
  localparam int InTdataW  = 224;
  localparam int OutTdataW = 32;

  // Q1.16 unit direction, the saturation bound of a loaded component.
  localparam logic signed [CoordW-1:0] DirOne    = 32'sd65536;
  localparam logic signed [CoordW-1:0] DirOneNeg = -32'sd65536;

  // Divider sizing: 31 quotient bits after the saturation pre-check.
  localparam int DivSteps = 31;
  localparam int DivCntW  = $clog2(DivSteps);

  // Item kinds carried on tuser.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_WAIT0,
    ST_WAIT1,
    ST_UPDATE,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  // Request to the shared divider: (bound - origin) * 2^16 / direction.
  typedef struct packed {
    logic               start;
    logic signed [32:0] dividend;
    logic signed [17:0] divisor;
  } div_req_t;

  // Divider status and saturated quotient.
  typedef struct packed {
    logic               done;
    logic               busy;
    logic signed [31:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div: shared radix-2 crossing-distance divider
// Computes (dividend * 2^16) / divisor, truncated toward zero and saturated
// to the signed 32-bit range. A pre-check catches saturation on a new request;
// otherwise 31 restoring steps produce one quotient bit each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbsi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbsi_pkg::div_req_t req_i,
  output rbsi_pkg::div_rsp_t rsp_o
);

  localparam logic [rbsi_pkg::DivCntW-1:0] DivLast =
    rbsi_pkg::DivCntW'(rbsi_pkg::DivSteps - 1);

  rbsi_pkg::div_state_e state_q, state_d;
  logic                         done_q, done_d;
  logic [rbsi_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [16:0]                  rem_q, rem_d;
  logic [30:0]                  shf_q, shf_d;
  logic [16:0]                  dvs_q, dvs_d;
  logic                         neg_q, neg_d;
  logic signed [31:0]           quot_q, quot_d;

  logic [32:0] abs_a;
  logic [31:0] mag_a;
  logic [17:0] abs_d;
  logic [16:0] mag_d;
  logic        neg_in;
  logic        sat;
  logic [17:0] trial;
  logic [17:0] trial_sub;
  logic        ge;

  // Operand magnitudes and the saturation pre-check on a new request.
  always_comb begin
    neg_in = req_i.dividend[32] ^ req_i.divisor[17];
    abs_a  = req_i.dividend[32] ? (33'd0 - req_i.dividend) : req_i.dividend;
    mag_a  = abs_a[31:0];
    abs_d  = req_i.divisor[17] ? (18'd0 - req_i.divisor) : req_i.divisor;
    mag_d  = abs_d[16:0];
    // The quotient reaches 2^31 exactly when the numerator shifted down by 31
    // is at least the divisor.
    sat    = (mag_a[31:15] >= mag_d);
  end

  // One restoring step.
  always_comb begin
    trial     = {rem_q, shf_q[30]};
    trial_sub = trial - {1'b0, dvs_q};
    ge        = (trial >= {1'b0, dvs_q});
  end

  // Sequencer of the divider.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    shf_d   = shf_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    quot_d  = quot_q;
    case (state_q)
      rbsi_pkg::DIV_IDLE: begin
        if (req_i.start) begin
          if (sat) begin
            done_d = 1'b1;
            quot_d = neg_in ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else begin
            state_d = rbsi_pkg::DIV_RUN;
            cnt_d   = '0;
            rem_d   = mag_a[31:15];
            shf_d   = {mag_a[14:0], 16'd0};
            dvs_d   = mag_d;
            neg_d   = neg_in;
          end
        end
      end
      rbsi_pkg::DIV_RUN: begin
        rem_d = ge ? trial_sub[16:0] : trial[16:0];
        shf_d = {shf_q[29:0], ge};
        cnt_d = cnt_q + rbsi_pkg::DivCntW'(1);
        if (cnt_q == DivLast) begin
          state_d = rbsi_pkg::DIV_IDLE;
          done_d  = 1'b1;
          quot_d  = neg_q ? (32'sd0 - $signed({1'b0, shf_d})) : $signed({1'b0, shf_d});
        end
      end
      default: begin
        state_d = rbsi_pkg::DIV_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbsi_pkg::DIV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    shf_q  <= shf_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.busy     = (state_q == rbsi_pkg::DIV_RUN);
  assign rsp_o.quotient = quot_q;

  // A new request arrives only while the divider is free.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == rbsi_pkg::DIV_IDLE)
    else $error("divider started while busy");

  // Zero directions never reach the divider.
  a_nonzero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.divisor != 18'sd0)
    else $error("divider started with zero divisor");

  // A finished division always leaves the unit idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == rbsi_pkg::DIV_IDLE)
    else $error("divider done while still running");

endmodule

`default_nettype wire

### hw/rtl/ray_box_slab_intersection.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersection: ray against axis-aligned box, slab test
// A load transfer stores the ray and gives no result. A box test walks
// the axes in turn: an axis with a zero direction is checked directly,
// any other takes two divisions on the shared divider.
// The block takes one item at a time; the input is ready only while idle.
// Reset: asynchronous, active low; the stored ray returns to a zero origin
// and zero direction and no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersection (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0 up: first_x, first_y, first_z, second_x, second_y,
  // second_z, limit, one zero pad bit.
  input  logic [rbsi_pkg::InTdataW-1:0]      s_axis_tdata,
  // tuser: action.
  input  logic                               s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0 up: entry_distance, one zero pad bit.
  output logic [rbsi_pkg::OutTdataW-1:0]     m_axis_tdata,
  // tuser: hit.
  output logic                               m_axis_tuser
);

  localparam int CW = rbsi_pkg::CoordW;
  localparam int NA = rbsi_pkg::StoredAxes;

  // Clamp a loaded direction component to +-1.0 in Q1.16.
  function automatic logic signed [rbsi_pkg::DirW-1:0] clamp_dir(
    input logic signed [CW-1:0] v
  );
    logic signed [CW-1:0] c;
    c = v;
    if (v > rbsi_pkg::DirOne) begin
      c = rbsi_pkg::DirOne;
    end else if (v < rbsi_pkg::DirOneNeg) begin
      c = rbsi_pkg::DirOneNeg;
    end
    return c[rbsi_pkg::DirW-1:0];
  endfunction

  rbsi_pkg::ctrl_state_e state_q, state_d;

  logic signed [CW-1:0]                org_q [NA];
  logic signed [rbsi_pkg::DirW-1:0]    dir_q [NA];
  logic signed [CW-1:0]                box_lo_q [NA];
  logic signed [CW-1:0]                box_hi_q [NA];

  logic [rbsi_pkg::AxisW-1:0] axis_q, axis_d;
  logic                       miss_q, miss_d;
  logic signed [CW-1:0]       t_near_q, t_near_d;
  logic signed [CW-1:0]       t_far_q, t_far_d;
  logic signed [CW-1:0]       t0_q, t0_d;
  logic signed [CW-1:0]       t1_q, t1_d;

  logic                       m_valid_q, m_valid_d;
  logic                       m_hit_q;
  logic [rbsi_pkg::DistW-1:0] m_dist_q;
  logic                       out_load;

  logic                       in_xfer;
  logic [rbsi_pkg::AxisIdxW-1:0] axis_idx;
  logic signed [CW-1:0]       cur_o;
  logic signed [CW-1:0]       cur_lo;
  logic signed [CW-1:0]       cur_hi;
  logic signed [rbsi_pkg::DirW-1:0] cur_d;
  logic signed [CW:0]         diff_lo;
  logic signed [CW:0]         diff_hi;
  logic signed [CW-1:0]       t_min;
  logic signed [CW-1:0]       t_max;

  rbsi_pkg::div_req_t div_req;
  rbsi_pkg::div_rsp_t div_rsp;

  assign s_axis_tready = (state_q == rbsi_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Operands of the current axis.
  always_comb begin
    axis_idx = (axis_q < rbsi_pkg::AxisW'(NA)) ? axis_q[rbsi_pkg::AxisIdxW-1:0] : '0;
    cur_o    = org_q[axis_idx];
    cur_d    = dir_q[axis_idx];
    cur_lo   = box_lo_q[axis_idx];
    cur_hi   = box_hi_q[axis_idx];
    diff_lo  = $signed({cur_lo[CW-1], cur_lo}) - $signed({cur_o[CW-1], cur_o});
    diff_hi  = $signed({cur_hi[CW-1], cur_hi}) - $signed({cur_o[CW-1], cur_o});
    t_min    = (t0_q > t1_q) ? t1_q : t0_q;
    t_max    = (t0_q > t1_q) ? t0_q : t1_q;
  end

  // Sequencer: next state, interval updates and divider requests.
  always_comb begin
    state_d          = state_q;
    axis_d           = axis_q;
    miss_d           = miss_q;
    t_near_d         = t_near_q;
    t_far_d          = t_far_q;
    t0_d             = t0_q;
    t1_d             = t1_q;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = diff_lo;
    div_req.divisor  = cur_d;
    case (state_q)
      rbsi_pkg::ST_IDLE: begin
        if (in_xfer && (s_axis_tuser == rbsi_pkg::ACT_TEST)) begin
          state_d  = rbsi_pkg::ST_AXIS;
          axis_d   = '0;
          miss_d   = 1'b0;
          t_near_d = '0;
          t_far_d  = $signed({1'b0, s_axis_tdata[6*CW +: rbsi_pkg::LimitW]});
        end
      end
      rbsi_pkg::ST_AXIS: begin
        if (t_near_q > t_far_q) begin
          miss_d  = 1'b1;
          state_d = rbsi_pkg::ST_DONE;
        end else if (axis_q == rbsi_pkg::AxisW'(rbsi_pkg::AxisLimit)) begin
          state_d = rbsi_pkg::ST_DONE;
        end else if (cur_d == '0) begin
          // A ray parallel to the slab must start inside it.
          if ((cur_o < cur_lo) || (cur_o > cur_hi)) begin
            miss_d  = 1'b1;
            state_d = rbsi_pkg::ST_DONE;
          end else begin
            axis_d = axis_q + rbsi_pkg::AxisW'(1);
          end
        end else begin
          div_req.start = 1'b1;
          state_d       = rbsi_pkg::ST_WAIT0;
        end
      end
      rbsi_pkg::ST_WAIT0: begin
        if (div_rsp.done) begin
          t0_d             = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = diff_hi;
          state_d          = rbsi_pkg::ST_WAIT1;
        end
      end
      rbsi_pkg::ST_WAIT1: begin
        if (div_rsp.done) begin
          t1_d    = div_rsp.quotient;
          state_d = rbsi_pkg::ST_UPDATE;
        end
      end
      rbsi_pkg::ST_UPDATE: begin
        // Narrow the interval with the ordered crossings.
        t_near_d = (t_min > t_near_q) ? t_min : t_near_q;
        t_far_d  = (t_max < t_far_q) ? t_max : t_far_q;
        axis_d   = axis_q + rbsi_pkg::AxisW'(1);
        state_d  = rbsi_pkg::ST_AXIS;
      end
      rbsi_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = rbsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rbsi_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // Control registers and the stored ray.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rbsi_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      axis_q    <= '0;
      miss_q    <= 1'b0;
      for (int i = 0; i < NA; i++) begin
        org_q[i] <= '0;
        dir_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      axis_q    <= axis_d;
      miss_q    <= miss_d;
      if (in_xfer && (s_axis_tuser == rbsi_pkg::ACT_LOAD)) begin
        for (int i = 0; i < NA; i++) begin
          org_q[i] <= s_axis_tdata[i*CW +: CW];
          dir_q[i] <= clamp_dir(s_axis_tdata[(NA+i)*CW +: CW]);
        end
      end
    end
  end

  // Box corners, interval and result payload.
  always_ff @(posedge clk_i) begin
    t_near_q <= t_near_d;
    t_far_q  <= t_far_d;
    t0_q     <= t0_d;
    t1_q     <= t1_d;
    if (in_xfer && (s_axis_tuser == rbsi_pkg::ACT_TEST)) begin
      for (int i = 0; i < NA; i++) begin
        box_lo_q[i] <= s_axis_tdata[i*CW +: CW];
        box_hi_q[i] <= s_axis_tdata[(NA+i)*CW +: CW];
      end
    end
    if (out_load) begin
      m_hit_q  <= !miss_q;
      m_dist_q <= miss_q ? '0 : t_near_q[rbsi_pkg::DistW-1:0];
    end
  end

  // Shared crossing-distance divider.
  rbsi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_dist_q};
  assign m_axis_tuser  = m_hit_q;

  // A miss always reports a zero entry distance.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == '0)
    else $error("miss result with nonzero distance");

  // The divider only finishes while the sequencer waits for it.
  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == rbsi_pkg::ST_WAIT0 || state_q == rbsi_pkg::ST_WAIT1))
    else $error("divider result arrived outside a wait state");

  // The entry distance never drops below zero during a test.
  a_near_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rbsi_pkg::ST_IDLE) |-> !t_near_q[CW-1])
    else $error("negative entry distance");

endmodule

`default_nettype wire
